[rtl/core/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, ignored while reset is asserted
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// checked property, evaluated during reset too
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

[rtl/core/jsu_pkg.sv]
// shared types and constants of the json string unescape block
package jsu_pkg;

  localparam logic [7:0] CharQuote = 8'h22;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharLowB = 8'h62;
  localparam logic [7:0] CharLowF = 8'h66;
  localparam logic [7:0] CharLowN = 8'h6E;
  localparam logic [7:0] CharLowR = 8'h72;
  localparam logic [7:0] CharLowT = 8'h74;
  localparam logic [7:0] CharLowU = 8'h75;
  localparam logic [7:0] CharSpace = 8'h20;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_NO_OPEN    = 3'd1,
    ERR_CONTROL    = 3'd2,
    ERR_BAD_ESC    = 3'd3,
    ERR_BAD_HEX    = 3'd4,
    ERR_MISSING_LO = 3'd5,
    ERR_BAD_LO     = 3'd6,
    ERR_UNTERM     = 3'd7
  } err_code_e;

  typedef enum logic [1:0] {
    JOB_BYTE = 2'd0,
    JOB_CP   = 2'd1,
    JOB_DONE = 2'd2,
    JOB_ERR  = 2'd3
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [20:0] cp;
    err_code_e   err;
  } job_t;

  // number of utf-8 bytes of a code point, minus one
  function automatic logic [1:0] utf8_last_idx(logic [20:0] cp);
    logic [1:0] n;
    if (cp <= 21'h7F) begin
      n = 2'd0;
    end else if (cp <= 21'h7FF) begin
      n = 2'd1;
    end else if (cp <= 21'hFFFF) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(logic [20:0] cp, logic [1:0] len_m1,
                                           logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (len_m1)
      2'd0: b = {1'b0, cp[6:0]};
      2'd1: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      2'd2: begin
        unique case (idx)
          2'd0: b = {4'b1110, cp[15:12]};
          2'd1: b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        unique case (idx)
          2'd0: b = {5'b11110, cp[20:18]};
          2'd1: b = {2'b10, cp[17:12]};
          2'd2: b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

[rtl/core/json_string_unescape_utf8.sv]
// top level of the json string unescape to utf-8 decoder
// path: each result of an accepted item goes through the job queue, then the registered output stage
// throughput: 1 input item per cycle; the output side moves 1 result per cycle while
// the master is ready, so an escape that yields n utf-8 bytes takes n output results and the
// job queue of FifoDepth entries absorbs the difference before input stalls
// reset: asynchronous active low, back to waiting for an opening quote, queue empty
module json_string_unescape_utf8 #(
  parameter int FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] in_byte
  input  logic       s_axis_tlast_i,  // end_of_text
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] out_byte
  output logic [4:0] m_axis_tuser_o,  // [0] byte_valid, [1] string_done, [4:2] error_code
  output logic       m_axis_tlast_o   // last_of_run
);
  import jsu_pkg::*;

  logic job_push_valid, job_push_ready, job_pop_valid, job_pop_ready;
  job_t job_push, job_pop;
  logic bv, done;
  logic [2:0] err;

  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_byte_i   (s_axis_tdata_i),
    .in_eot_i    (s_axis_tlast_i),
    .job_valid_o (job_push_valid),
    .job_ready_i (job_push_ready),
    .job_o       (job_push)
  );

  jsu_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_push_valid),
    .push_ready_o (job_push_ready),
    .push_data_i  (job_push),
    .pop_valid_o  (job_pop_valid),
    .pop_ready_i  (job_pop_ready),
    .pop_data_o   (job_pop)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_pop_valid),
    .job_ready_o  (job_pop_ready),
    .job_i        (job_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (m_axis_tdata_o),
    .byte_valid_o (bv),
    .last_o       (m_axis_tlast_o),
    .done_o       (done),
    .err_o        (err)
  );

  assign m_axis_tuser_o = {err, done, bv};

endmodule

[rtl/core/jsu_fifo.sv]
// job queue between the decoder front and the byte emitter
module jsu_fifo #(
  parameter int Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  jsu_pkg::job_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output jsu_pkg::job_t pop_data_o
);
  import jsu_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/core/jsu_front.sv]
// byte classifier and escape decoder, one input item per cycle while the job queue is ready
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          in_eot_i,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output jsu_pkg::job_t job_o
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_BODY    = 3'd1,
    PH_ESC     = 3'd2,
    PH_HEX1    = 3'd3,
    PH_WANT_BS = 3'd4,
    PH_WANT_U  = 3'd5,
    PH_HEX2    = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] acc_q, acc_d;
  logic [15:0] hs_q, hs_d;
  logic        emit;
  job_t        job;
  logic [3:0]  hexv;
  logic        hex_ok;
  logic [15:0] acc_new;
  logic        accept;

  assign in_ready_o  = job_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign job_valid_o = accept && emit;
  assign job_o       = job;

  always_comb begin
    hex_ok = 1'b1;
    hexv   = 4'h0;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      hexv = in_byte_i[3:0];
    end else if ((in_byte_i >= 8'h61 && in_byte_i <= 8'h66) ||
                 (in_byte_i >= 8'h41 && in_byte_i <= 8'h46)) begin
      hexv = in_byte_i[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign acc_new = {acc_q[11:0], hexv};

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    hs_d    = hs_q;
    emit    = 1'b0;
    job     = '{kind: JOB_BYTE, cp: '0, err: ERR_NONE};
    if (in_eot_i) begin
      emit     = 1'b1;
      job.kind = JOB_ERR;
      if (phase_q == PH_IDLE) begin
        job.err = ERR_NO_OPEN;
      end else if (phase_q == PH_WANT_BS || phase_q == PH_WANT_U) begin
        job.err = ERR_MISSING_LO;
      end else begin
        job.err = ERR_UNTERM;
      end
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          if (in_byte_i == CharQuote) begin
            phase_d = PH_BODY;
          end else begin
            emit     = 1'b1;
            job.kind = JOB_ERR;
            job.err  = ERR_NO_OPEN;
          end
        end
        PH_BODY: begin
          emit = 1'b1;
          if (in_byte_i == CharQuote) begin
            job.kind = JOB_DONE;
          end else if (in_byte_i == CharBslash) begin
            emit    = 1'b0;
            phase_d = PH_ESC;
          end else if (in_byte_i < CharSpace) begin
            job.kind = JOB_ERR;
            job.err  = ERR_CONTROL;
          end else begin
            job.cp = {13'd0, in_byte_i};
          end
        end
        PH_ESC: begin
          emit    = 1'b1;
          phase_d = PH_BODY;
          unique case (in_byte_i)
            CharQuote, CharBslash, CharSlash: job.cp = {13'd0, in_byte_i};
            CharLowB: job.cp = 21'h08;
            CharLowF: job.cp = 21'h0C;
            CharLowN: job.cp = 21'h0A;
            CharLowR: job.cp = 21'h0D;
            CharLowT: job.cp = 21'h09;
            CharLowU: begin
              emit    = 1'b0;
              phase_d = PH_HEX1;
              cnt_d   = 2'd0;
              acc_d   = '0;
            end
            default: begin
              job.kind = JOB_ERR;
              job.err  = ERR_BAD_ESC;
            end
          endcase
        end
        PH_HEX1, PH_HEX2: begin
          if (!hex_ok) begin
            emit     = 1'b1;
            job.kind = JOB_ERR;
            job.err  = ERR_BAD_HEX;
          end else if (cnt_q != 2'd3) begin
            cnt_d = cnt_q + 2'd1;
            acc_d = acc_new;
          end else begin
            cnt_d = 2'd0;
            if (phase_q == PH_HEX1) begin
              if (acc_new[15:10] == 6'b110110) begin
                hs_d    = acc_new;
                acc_d   = '0;
                phase_d = PH_WANT_BS;
              end else begin
                acc_d    = acc_new;
                phase_d  = PH_BODY;
                emit     = 1'b1;
                job.kind = JOB_CP;
                job.cp   = {5'd0, acc_new};
              end
            end else begin
              emit = 1'b1;
              if (acc_new[15:10] != 6'b110111) begin
                job.kind = JOB_ERR;
                job.err  = ERR_BAD_LO;
              end else begin
                job.kind = JOB_CP;
                job.cp   = 21'h10000 + {1'b0, hs_q[9:0], acc_new[9:0]};
                phase_d  = PH_BODY;
                acc_d    = '0;
                hs_d     = '0;
              end
            end
          end
        end
        PH_WANT_BS: begin
          if (in_byte_i == CharBslash) begin
            phase_d = PH_WANT_U;
          end else begin
            emit     = 1'b1;
            job.kind = JOB_ERR;
            job.err  = ERR_MISSING_LO;
          end
        end
        PH_WANT_U: begin
          if (in_byte_i == CharLowU) begin
            phase_d = PH_HEX2;
            cnt_d   = 2'd0;
            acc_d   = '0;
          end else begin
            emit     = 1'b1;
            job.kind = JOB_ERR;
            job.err  = ERR_MISSING_LO;
          end
        end
        default: begin
          emit     = 1'b1;
          job.kind = JOB_ERR;
          job.err  = ERR_NO_OPEN;
        end
      endcase
    end
    if (emit && (job.kind == JOB_ERR || job.kind == JOB_DONE)) begin
      phase_d = PH_IDLE;
      cnt_d   = '0;
      acc_d   = '0;
      hs_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      acc_q   <= '0;
      hs_q    <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      hs_q    <= hs_d;
    end
  end

endmodule

[rtl/core/jsu_back.sv]
// utf-8 byte emitter with a registered output stage
module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  jsu_pkg::job_t job_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          byte_valid_o,
  output logic          last_o,
  output logic          done_o,
  output logic [2:0]    err_o
);
  import jsu_pkg::*;

  logic       valid_q;
  logic [7:0] byte_q, byte_d;
  logic       bv_q, bv_d, last_q, last_d, done_q, done_d;
  logic [2:0] err_q, err_d;
  logic [1:0] idx_q, idx_d;
  logic [1:0] len_m1;
  logic       load;

  assign load        = !valid_q || out_ready_i;
  assign job_ready_o = load && last_d;

  always_comb begin
    len_m1 = (job_i.kind == JOB_CP) ? utf8_last_idx(job_i.cp) : 2'd0;
    byte_d = 8'h00;
    bv_d   = 1'b0;
    done_d = 1'b0;
    err_d  = ERR_NONE;
    last_d = (idx_q == len_m1);
    unique case (job_i.kind)
      JOB_BYTE: begin
        byte_d = job_i.cp[7:0];
        bv_d   = 1'b1;
      end
      JOB_CP: begin
        byte_d = utf8_byte(job_i.cp, len_m1, idx_q);
        bv_d   = 1'b1;
      end
      JOB_DONE: done_d = 1'b1;
      default:  err_d  = job_i.err;
    endcase
    idx_d = idx_q;
    if (load && job_valid_i) begin
      idx_d = last_d ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        valid_q <= job_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      bv_q   <= bv_d;
      last_q <= last_d;
      done_q <= done_d;
      err_q  <= err_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign byte_valid_o = bv_q;
  assign last_o       = last_q;
  assign done_o       = done_q;
  assign err_o        = err_q;

endmodule

[rtl/core/jsu_checker.sv]
// port-level checks of the json string unescape decoder and their binding
`include "assert_macros.svh"

module jsu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic [7:0] s_axis_tdata_i,
  input logic       s_axis_tlast_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic [4:0] m_axis_tuser_o,
  input logic       m_axis_tlast_o
);

  `ASSERT_RST(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
  `ASSERT_RST(a_status_alone, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tlast_o && m_axis_tdata_o == 8'h00)
  `ASSERT_RST(a_byte_clean, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[0] |-> !m_axis_tuser_o[1] && m_axis_tuser_o[4:2] == 3'd0)
  `ASSERT_RST(a_status_marked, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tuser_o[1] != (m_axis_tuser_o[4:2] != 3'd0))
  `ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !m_axis_tvalid_o)

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);
